// ===== hdl/swl_pkg.sv =====
package swl_pkg;

   localparam int NUM_COLUMNS_DEF = 32;
   localparam int COL_W           = 5;
   localparam int ROW_W           = 8;
   localparam int PHASE_W         = 5;
   localparam int WAVE_W          = 4;
   localparam int WAVE_DEPTH      = 32;

   localparam logic [ROW_W-1:0] ROW_LIMIT  = 8'd192;
   localparam logic [ROW_W-1:0] ROW_NONE   = 8'hFF;
   localparam logic [ROW_W-1:0] BASE_MIN   = 8'd6;
   localparam logic [ROW_W-1:0] BASE_MAX   = 8'd198;
   localparam logic [ROW_W-1:0] CULL_OFS   = 8'd7;
   localparam logic [ROW_W-1:0] CLAMP_OFS  = 8'd6;
   localparam logic [ROW_W-1:0] CLAMP_MASK = 8'h07;

   localparam logic signed [WAVE_W-1:0] WAVE_TAB [WAVE_DEPTH] = '{
       4'sd0,  4'sd1,  4'sd2,  4'sd3,  4'sd4,  4'sd5,  4'sd5,  4'sd6,
       4'sd6,  4'sd6,  4'sd5,  4'sd5,  4'sd4,  4'sd3,  4'sd2,  4'sd1,
       4'sd0, -4'sd1, -4'sd2, -4'sd3, -4'sd4, -4'sd5, -4'sd5, -4'sd6,
      -4'sd6, -4'sd6, -4'sd5, -4'sd5, -4'sd4, -4'sd3, -4'sd2, -4'sd1
   };

   typedef struct packed {
      logic             func;
      logic [ROW_W-1:0] base_row;
   } req_type;

   typedef struct packed {
      logic             op_valid;
      logic [COL_W-1:0] column;
      logic [ROW_W-1:0] row;
      logic             last;
      logic             visible;
      logic [ROW_W-1:0] cull_row;
      logic [ROW_W-1:0] clamp_row;
   } rsp_type;

   typedef struct packed {
      logic             push;
      logic             finish;
      logic [COL_W-1:0] column;
      logic [ROW_W-1:0] row;
      logic             visible;
      logic [ROW_W-1:0] cull_row;
      logic [ROW_W-1:0] clamp_row;
   } emit_type;

   function automatic logic signed [WAVE_W-1:0] wave_offset(input logic [PHASE_W-1:0] idx);
      return WAVE_TAB[idx];
   endfunction

endpackage

// ===== hdl/sine_wave_line_xor_renderer.sv =====
// Results: the first result is valid in the cycle after the step that emits the item's second XOR,
//   or after its finish step; a result stall holds the sequencer until the output can take the item.
// Sequencing: an update runs one erase step and one draw step per column, then finish and idle;
//   an erase runs one erase step per column, then finish and idle; new requests stall until idle.
// Reset: synchronous; clears phase, base row, shown flag, sequencer, output stage and the
//   per-column valid bits, so every stored row reads as none right after reset.
module sine_wave_line_xor_renderer #(
   parameter int NUM_COLUMNS = swl_pkg::NUM_COLUMNS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  swl_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output swl_pkg::rsp_type rsp_data
);
   import swl_pkg::*;

   localparam int ADDR_W = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
   localparam logic [ADDR_W-1:0] LAST_COL = ADDR_W'(NUM_COLUMNS - 1);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_ERASE = 2'd1;
   localparam logic [1:0] S_DRAW  = 2'd2;
   localparam logic [1:0] S_FIN   = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [ADDR_W-1:0]  col_ff, col_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [ROW_W-1:0]   base_reg_ff, base_reg_in;
   logic               shown_ff, shown_in;
   logic               wipe_ff, wipe_in;

   logic               req_go;
   logic               base_bad;
   logic               rd_en;
   logic [ADDR_W-1:0]  rd_addr;
   logic [ROW_W-1:0]   prev_row;
   logic               wr_en;
   logic [ROW_W-1:0]   wr_data;
   logic               erase_hit;
   logic [PHASE_W-1:0] wave_idx;
   logic signed [WAVE_W-1:0] wave;
   logic signed [9:0]  new_row;
   logic               draw_hit;
   logic [ROW_W-1:0]   cull;
   logic [ROW_W-1:0]   clamp;
   emit_type           emit;
   logic               emit_rdy;
   logic               step;

   assign req_stall = (state_ff != S_IDLE);
   assign req_go    = req_valid && !req_stall;
   assign base_bad  = (req_data.base_row > BASE_MAX) || (req_data.base_row < BASE_MIN);

   assign erase_hit = prev_row < ROW_LIMIT;
   assign wave_idx  = PHASE_W'(col_ff) + phase_ff;
   assign wave      = wave_offset(wave_idx);
   assign new_row   = $signed({2'b00, base_reg_ff}) + $signed({{(10-WAVE_W){wave[WAVE_W-1]}}, wave});
   assign draw_hit  = !new_row[9] && (new_row[8:0] < {1'b0, ROW_LIMIT});

   assign cull  = (shown_ff && (base_reg_ff >= CULL_OFS)) ? (base_reg_ff - CULL_OFS) : '0;
   assign clamp = shown_ff ? (((base_reg_ff + CLAMP_OFS) | CLAMP_MASK) + 8'd1) : '0;

   always_comb begin
      emit           = '0;
      emit.column    = COL_W'(col_ff);
      emit.visible   = shown_ff;
      emit.cull_row  = cull;
      emit.clamp_row = clamp;
      unique case (state_ff)
         S_ERASE: begin
            emit.push = erase_hit;
            emit.row  = prev_row;
         end
         S_DRAW: begin
            emit.push = draw_hit;
            emit.row  = new_row[ROW_W-1:0];
         end
         S_FIN: begin
            emit.finish = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign step = !(emit.push || emit.finish) || emit_rdy;

   always_comb begin
      state_in    = state_ff;
      col_in      = col_ff;
      phase_in    = phase_ff;
      base_reg_in = base_reg_ff;
      shown_in    = shown_ff;
      wipe_in     = wipe_ff;
      rd_en       = 1'b0;
      rd_addr     = col_ff + ADDR_W'(1);
      wr_en       = 1'b0;
      wr_data     = ROW_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_go) begin
               rd_en    = 1'b1;
               rd_addr  = '0;
               col_in   = '0;
               state_in = S_ERASE;
               if (req_data.func) begin
                  wipe_in = 1'b1;
               end else begin
                  base_reg_in = req_data.base_row;
                  wipe_in     = base_bad;
                  shown_in    = !base_bad;
               end
            end
         end
         S_ERASE: begin
            if (step) begin
               if (wipe_ff) begin
                  wr_en = 1'b1;
                  if (col_ff == LAST_COL) begin
                     state_in = S_FIN;
                  end else begin
                     rd_en    = 1'b1;
                     col_in   = col_ff + ADDR_W'(1);
                  end
               end else begin
                  state_in = S_DRAW;
               end
            end
         end
         S_DRAW: begin
            if (step) begin
               wr_en   = 1'b1;
               wr_data = draw_hit ? new_row[ROW_W-1:0] : ROW_NONE;
               if (col_ff == LAST_COL) begin
                  state_in = S_FIN;
               end else begin
                  rd_en    = 1'b1;
                  col_in   = col_ff + ADDR_W'(1);
                  state_in = S_ERASE;
               end
            end
         end
         S_FIN: begin
            if (step) begin
               if (!wipe_ff) begin
                  phase_in = phase_ff + PHASE_W'(1);
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         col_ff      <= '0;
         phase_ff    <= '0;
         base_reg_ff <= '0;
         shown_ff    <= 1'b0;
         wipe_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         col_ff      <= col_in;
         phase_ff    <= phase_in;
         base_reg_ff <= base_reg_in;
         shown_ff    <= shown_in;
         wipe_ff     <= wipe_in;
      end
   end

   swl_row_mem #(
      .NUM_COLUMNS (NUM_COLUMNS),
      .ADDR_W      (ADDR_W)
   ) u_row_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (prev_row),
      .wr_en   (wr_en),
      .wr_addr (col_ff),
      .wr_data (wr_data)
   );

   swl_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .emit      (emit),
      .emit_rdy  (emit_rdy),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   a_draw_not_wipe: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DRAW) |-> !wipe_ff)
      else $error("draw step during an erase item");

   a_row_stored: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> ((wr_data < ROW_LIMIT) || (wr_data == ROW_NONE)))
      else $error("stored row out of screen range");

endmodule

// ===== hdl/swl_row_mem.sv =====
module swl_row_mem #(
   parameter int NUM_COLUMNS = swl_pkg::NUM_COLUMNS_DEF,
   parameter int ADDR_W      = 5
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     rd_en,
   input  logic [ADDR_W-1:0]        rd_addr,
   output logic [swl_pkg::ROW_W-1:0] rd_data,
   input  logic                     wr_en,
   input  logic [ADDR_W-1:0]        wr_addr,
   input  logic [swl_pkg::ROW_W-1:0] wr_data
);
   import swl_pkg::*;

   logic [ROW_W-1:0]       row_mem [NUM_COLUMNS];
   logic [NUM_COLUMNS-1:0] vld_ff;
   logic [NUM_COLUMNS-1:0] vld_in;
   logic [ROW_W-1:0]       rd_data_ff;
   logic                   rd_vld_ff;

   always_comb begin
      vld_in = vld_ff;
      if (wr_en) begin
         vld_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= row_mem[rd_addr];
         rd_vld_ff  <= vld_ff[rd_addr];
      end
   end

   assign rd_data = rd_vld_ff ? rd_data_ff : ROW_NONE;

endmodule

// ===== hdl/swl_emit.sv =====
module swl_emit (
   input  logic              clock,
   input  logic              reset,
   input  swl_pkg::emit_type emit,
   output logic              emit_rdy,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output swl_pkg::rsp_type  rsp_data
);
   import swl_pkg::*;

   logic             out_vld_ff, out_vld_in;
   rsp_type          out_ff, out_in;
   logic             pend_vld_ff, pend_vld_in;
   logic [COL_W-1:0] pend_col_ff, pend_col_in;
   logic [ROW_W-1:0] pend_row_ff, pend_row_in;
   logic             out_free;
   logic             go_push;
   logic             go_fin;

   assign out_free = !out_vld_ff || !rsp_stall;
   assign emit_rdy = out_free || (emit.push && !pend_vld_ff);
   assign go_push  = emit.push && emit_rdy;
   assign go_fin   = emit.finish && emit_rdy;

   always_comb begin
      out_vld_in  = out_vld_ff && rsp_stall;
      out_in      = out_ff;
      pend_vld_in = pend_vld_ff;
      pend_col_in = pend_col_ff;
      pend_row_in = pend_row_ff;
      if (go_push) begin
         if (pend_vld_ff) begin
            out_vld_in = 1'b1;
            out_in     = '{op_valid: 1'b1, column: pend_col_ff, row: pend_row_ff,
                           last: 1'b0, visible: emit.visible,
                           cull_row: emit.cull_row, clamp_row: emit.clamp_row};
         end
         pend_vld_in = 1'b1;
         pend_col_in = emit.column;
         pend_row_in = emit.row;
      end else if (go_fin) begin
         out_vld_in  = 1'b1;
         out_in      = '{op_valid: pend_vld_ff,
                         column: pend_vld_ff ? pend_col_ff : '0,
                         row: pend_vld_ff ? pend_row_ff : '0,
                         last: 1'b1, visible: emit.visible,
                         cull_row: emit.cull_row, clamp_row: emit.clamp_row};
         pend_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         pend_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         pend_vld_ff <= pend_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff      <= out_in;
      pend_col_ff <= pend_col_in;
      pend_row_ff <= pend_row_in;
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

   a_fin_last: assert property (@(posedge clock) disable iff (reset)
      go_fin |=> (rsp_valid && rsp_data.last && !pend_vld_ff))
      else $error("finish did not present a last item");

   a_marker_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.op_valid) |-> rsp_data.last)
      else $error("marker item without last");

endmodule
